// ===== hdl/fas_pkg.sv =====
// types, codes and reset constants of the flight arming supervisor
package fas_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned SP_W = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] POWER_ON_DELAY_RST = 32'd3000000;
    localparam logic [TIME_W-1:0] ARMING_TIME_RST = 32'd4000000;
    localparam logic [TIME_W-1:0] RADIO_TIMEOUT_RST = 32'd1000000;
    localparam logic [TIME_W-1:0] IMU_PERIOD_RST = 32'd4000;
    localparam logic [TIME_W-1:0] MAG_PERIOD_RST = 32'd50000;
    localparam logic [TIME_W-1:0] CONTROL_PERIOD_RST = 32'd4000;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARMING_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIO_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd5;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_POWER_ON = 3'd1,
        MODE_CALIB = 3'd2,
        MODE_WAIT_ARM = 3'd3,
        MODE_ARMING = 3'd4,
        MODE_RUNNING = 3'd5,
        MODE_FAILSAFE = 3'd6,
        MODE_STOPPING = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ARM = 2'd1,
        EV_DISARM = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ARM_DISARM = 2'd1,
        CMD_STICKS = 2'd2,
        CMD_OTHER = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_us;
        cmd_t cmd;
        logic arm_request;
        logic signed [SP_W-1:0] stick_roll;
        logic signed [SP_W-1:0] stick_pitch;
        logic signed [SP_W-1:0] stick_yaw;
        logic signed [SP_W-1:0] stick_throttle;
    } pass_t;

    typedef struct packed {
        mode_t mode;
        logic armed;
        logic imu_ready;
        logic mag_update;
        logic imu_read;
        logic calibrate;
        logic esc_idle;
        logic run_control;
        logic signed [SP_W-1:0] set_roll;
        logic signed [SP_W-1:0] set_pitch;
        logic signed [SP_W-1:0] set_yaw;
        logic signed [SP_W-1:0] set_throttle;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] power_on_delay_us;
        logic [TIME_W-1:0] arming_time_us;
        logic [TIME_W-1:0] radio_silence_us;
        logic [TIME_W-1:0] imu_period_us;
        logic [TIME_W-1:0] mag_period_us;
        logic [TIME_W-1:0] control_period_us;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        event_t pending;
        logic [TIME_W-1:0] power_on_start;
        logic [TIME_W-1:0] arming_start;
        logic [TIME_W-1:0] last_radio;
        logic [TIME_W-1:0] last_imu;
        logic [TIME_W-1:0] last_mag;
        logic [TIME_W-1:0] last_control;
        logic armed;
        logic calibrated;
        logic signed [SP_W-1:0] roll;
        logic signed [SP_W-1:0] pitch;
        logic signed [SP_W-1:0] yaw;
        logic signed [SP_W-1:0] throttle;
    } state_t;

    function automatic logic elapsed(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] stamp,
        input logic [TIME_W-1:0] period
    );
        logic [TIME_W-1:0] diff;
        diff = now - stamp;
        return diff >= period;
    endfunction

endpackage

// ===== hdl/fas_ifs.sv =====
// valid/ready channel interfaces for loop passes and results
interface fas_pass_if;
    logic valid;
    logic ready;
    fas_pkg::pass_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fas_result_if;
    logic valid;
    logic ready;
    fas_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/flight_arming_supervisor.sv =====
// top level of the flight arming supervisor
// Each transaction on pass is one control loop pass and gives exactly one
// transaction on result. A pass is held in an input register, goes through
// the mode, timer and packet logic combinationally, and lands in the result
// register together with the updated state; one pass per cycle is sustained
// while result is not stalled. Configuration writes through cfg_we take
// effect at once and are meant for times when no pass is in flight.
module flight_arming_supervisor (
    input  logic clk,
    input  logic rst_n,
    fas_pass_if.sink pass,
    fas_result_if.source result,
    input  logic cfg_we,
    input  logic [fas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fas_pkg::TIME_W-1:0] cfg_data
);

    fas_pkg::cfg_t cfg;

    logic in_valid_reg;
    fas_pkg::pass_t in_item_reg;
    logic out_valid_reg;
    fas_pkg::result_t out_item_reg;
    fas_pkg::state_t state_reg;
    fas_pkg::state_t state_next;
    fas_pkg::result_t res_next;
    logic advance;

    fas_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fas_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign pass.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pass.ready)
        begin
            in_valid_reg <= pass.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass.ready && pass.valid)
        begin
            in_item_reg <= pass.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: fas_pkg::MODE_POWER_ON, pending: fas_pkg::EV_NONE,
                           default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= res_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_item_reg;

`ifndef SYNTHESIS
    a_failsafe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == fas_pkg::MODE_FAILSAFE |=> state_reg.mode == fas_pkg::MODE_FAILSAFE)
        else $error("failsafe mode left");

    a_armed_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.armed |-> (state_reg.mode == fas_pkg::MODE_RUNNING ||
                             state_reg.mode == fas_pkg::MODE_FAILSAFE))
        else $error("armed outside running or failsafe");

    a_calib_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.calibrate |->
            out_item_reg.mode == fas_pkg::MODE_WAIT_ARM && out_item_reg.imu_ready)
        else $error("calibration pulse without entering wait for arm");
`endif

endmodule

// ===== hdl/fas_cfg_regs.sv =====
// configuration register bank of the flight arming supervisor
module fas_cfg_regs (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [fas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fas_pkg::TIME_W-1:0] cfg_data,
    output fas_pkg::cfg_t cfg
);

    fas_pkg::cfg_t cfg_reg;
    fas_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fas_pkg::REG_POWER_ON_DELAY: cfg_next.power_on_delay_us = cfg_data;
                fas_pkg::REG_ARMING_TIME:    cfg_next.arming_time_us = cfg_data;
                fas_pkg::REG_RADIO_TIMEOUT:  cfg_next.radio_silence_us = cfg_data;
                fas_pkg::REG_IMU_PERIOD:     cfg_next.imu_period_us = cfg_data;
                fas_pkg::REG_MAG_PERIOD:     cfg_next.mag_period_us = cfg_data;
                fas_pkg::REG_CONTROL_PERIOD: cfg_next.control_period_us = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_delay_us <= fas_pkg::POWER_ON_DELAY_RST;
            cfg_reg.arming_time_us <= fas_pkg::ARMING_TIME_RST;
            cfg_reg.radio_silence_us <= fas_pkg::RADIO_TIMEOUT_RST;
            cfg_reg.imu_period_us <= fas_pkg::IMU_PERIOD_RST;
            cfg_reg.mag_period_us <= fas_pkg::MAG_PERIOD_RST;
            cfg_reg.control_period_us <= fas_pkg::CONTROL_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/fas_step.sv =====
// one loop pass: packet handling, timeout, sensor pulses and mode machine
module fas_step (
    input  fas_pkg::state_t cur,
    input  fas_pkg::pass_t item,
    input  fas_pkg::cfg_t cfg,
    output fas_pkg::state_t nxt,
    output fas_pkg::result_t res
);

    logic mag_p;
    logic imu_p;
    logic cal_p;
    logic esc_p;
    logic ctl_p;

    always_comb
    begin
        nxt = cur;
        mag_p = 1'b0;
        imu_p = 1'b0;
        cal_p = 1'b0;
        esc_p = 1'b0;
        ctl_p = 1'b0;

        // radio packet
        if (item.cmd != fas_pkg::CMD_NONE)
        begin
            nxt.last_radio = item.now_us;
            if (item.cmd == fas_pkg::CMD_ARM_DISARM)
            begin
                nxt.pending = item.arm_request ? fas_pkg::EV_ARM : fas_pkg::EV_DISARM;
            end
            else if (item.cmd == fas_pkg::CMD_STICKS)
            begin
                nxt.roll = item.stick_roll;
                nxt.pitch = item.stick_pitch;
                nxt.yaw = item.stick_yaw;
                nxt.throttle = item.stick_throttle;
            end
        end

        if (fas_pkg::elapsed(item.now_us, nxt.last_radio, cfg.radio_silence_us))
        begin
            nxt.pending = fas_pkg::EV_TIMEOUT;
        end

        // sensor pulses use the flag from before this pass
        if (cur.calibrated)
        begin
            if (fas_pkg::elapsed(item.now_us, cur.last_mag, cfg.mag_period_us))
            begin
                mag_p = 1'b1;
                nxt.last_mag = item.now_us;
            end
            if (fas_pkg::elapsed(item.now_us, cur.last_imu, cfg.imu_period_us))
            begin
                imu_p = 1'b1;
                nxt.last_imu = item.now_us;
            end
        end

        case (cur.mode)
            fas_pkg::MODE_IDLE:
            begin
                nxt.mode = fas_pkg::MODE_POWER_ON;
                nxt.power_on_start = item.now_us;
            end
            fas_pkg::MODE_POWER_ON:
            begin
                if (fas_pkg::elapsed(item.now_us, cur.power_on_start,
                                     cfg.power_on_delay_us))
                begin
                    nxt.mode = fas_pkg::MODE_CALIB;
                end
            end
            fas_pkg::MODE_CALIB:
            begin
                cal_p = 1'b1;
                nxt.calibrated = 1'b1;
                nxt.mode = fas_pkg::MODE_WAIT_ARM;
            end
            fas_pkg::MODE_WAIT_ARM:
            begin
                if (nxt.pending == fas_pkg::EV_ARM)
                begin
                    nxt.pending = fas_pkg::EV_NONE;
                    nxt.mode = fas_pkg::MODE_ARMING;
                    nxt.arming_start = item.now_us;
                end
            end
            fas_pkg::MODE_ARMING:
            begin
                esc_p = 1'b1;
                if (fas_pkg::elapsed(item.now_us, cur.arming_start, cfg.arming_time_us))
                begin
                    nxt.mode = fas_pkg::MODE_RUNNING;
                    nxt.armed = 1'b1;
                end
            end
            fas_pkg::MODE_RUNNING:
            begin
                if (nxt.pending == fas_pkg::EV_DISARM)
                begin
                    nxt.pending = fas_pkg::EV_NONE;
                    nxt.mode = fas_pkg::MODE_WAIT_ARM;
                    nxt.armed = 1'b0;
                end
                else if (nxt.pending == fas_pkg::EV_TIMEOUT)
                begin
                    nxt.pending = fas_pkg::EV_NONE;
                    nxt.mode = fas_pkg::MODE_FAILSAFE;
                end
                else if (fas_pkg::elapsed(item.now_us, cur.last_control,
                                          cfg.control_period_us))
                begin
                    ctl_p = 1'b1;
                    nxt.last_control = item.now_us;
                end
            end
            fas_pkg::MODE_FAILSAFE:
            begin
                esc_p = 1'b1;
            end
            default:
            begin
                nxt.mode = cur.mode;
            end
        endcase
    end

    always_comb
    begin
        res.mode = nxt.mode;
        res.armed = nxt.armed;
        res.imu_ready = nxt.calibrated;
        res.mag_update = mag_p;
        res.imu_read = imu_p;
        res.calibrate = cal_p;
        res.esc_idle = esc_p;
        res.run_control = ctl_p;
        res.set_roll = nxt.roll;
        res.set_pitch = nxt.pitch;
        res.set_yaw = nxt.yaw;
        res.set_throttle = nxt.throttle;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the flight arming supervisor with its own mode predictor
module tb;

    typedef struct packed {
        fas_pkg::mode_t mode;
        fas_pkg::event_t pending;
        logic [fas_pkg::TIME_W-1:0] power_on_start;
        logic [fas_pkg::TIME_W-1:0] arming_start;
        logic [fas_pkg::TIME_W-1:0] last_radio;
        logic [fas_pkg::TIME_W-1:0] last_imu;
        logic [fas_pkg::TIME_W-1:0] last_mag;
        logic [fas_pkg::TIME_W-1:0] last_control;
        logic armed;
        logic calibrated;
        logic signed [fas_pkg::SP_W-1:0] roll;
        logic signed [fas_pkg::SP_W-1:0] pitch;
        logic signed [fas_pkg::SP_W-1:0] yaw;
        logic signed [fas_pkg::SP_W-1:0] throttle;
    } flight_state_t;

    localparam logic [fas_pkg::TIME_W-1:0] T_MAX = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fas_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fas_pkg::TIME_W-1:0] cfg_data;

    fas_pass_if pass_ch ();
    fas_result_if result_ch ();

    flight_arming_supervisor dut (
        .clk(clk),
        .rst_n(rst_n),
        .pass(pass_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [fas_pkg::TIME_W-1:0] cfg_regs [0:5];
    flight_state_t model_state;
    flight_state_t steer_state;
    fas_pkg::pass_t pending_passes [$];
    fas_pkg::result_t expected_results [$];
    int queued_count;
    int accepted_count;
    int result_count;
    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    logic pass_taken;
    logic failsafe_allowed;
    logic [fas_pkg::TIME_W-1:0] last_now;
    logic [fas_pkg::TIME_W-1:0] step_max;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic flight_state_t reset_flight_state();
        flight_state_t st;
        st = '0;
        st.mode = fas_pkg::MODE_POWER_ON;
        st.pending = fas_pkg::EV_NONE;
        return st;
    endfunction

    function automatic logic period_passed(
        input logic [fas_pkg::TIME_W-1:0] now,
        input logic [fas_pkg::TIME_W-1:0] stamp,
        input logic [fas_pkg::TIME_W-1:0] span
    );
        return fas_pkg::TIME_W'(now - stamp) >= span;
    endfunction

    // one loop pass: packet, radio timeout, sensor pulses, then the mode machine
    function automatic fas_pkg::result_t supervise_pass(inout flight_state_t st,
                                                        input fas_pkg::pass_t p);
        fas_pkg::result_t r;
        r = '0;
        if (p.cmd != fas_pkg::CMD_NONE)
        begin
            st.last_radio = p.now_us;
            if (p.cmd == fas_pkg::CMD_ARM_DISARM)
                st.pending = p.arm_request ? fas_pkg::EV_ARM : fas_pkg::EV_DISARM;
            else if (p.cmd == fas_pkg::CMD_STICKS)
            begin
                st.roll = p.stick_roll;
                st.pitch = p.stick_pitch;
                st.yaw = p.stick_yaw;
                st.throttle = p.stick_throttle;
            end
        end
        if (period_passed(p.now_us, st.last_radio, cfg_regs[fas_pkg::REG_RADIO_TIMEOUT]))
            st.pending = fas_pkg::EV_TIMEOUT;
        if (st.calibrated)
        begin
            if (period_passed(p.now_us, st.last_mag, cfg_regs[fas_pkg::REG_MAG_PERIOD]))
            begin
                r.mag_update = 1'b1;
                st.last_mag = p.now_us;
            end
            if (period_passed(p.now_us, st.last_imu, cfg_regs[fas_pkg::REG_IMU_PERIOD]))
            begin
                r.imu_read = 1'b1;
                st.last_imu = p.now_us;
            end
        end
        case (st.mode)
            fas_pkg::MODE_IDLE:
            begin
                st.mode = fas_pkg::MODE_POWER_ON;
                st.power_on_start = p.now_us;
            end
            fas_pkg::MODE_POWER_ON:
                if (period_passed(p.now_us, st.power_on_start,
                                  cfg_regs[fas_pkg::REG_POWER_ON_DELAY]))
                    st.mode = fas_pkg::MODE_CALIB;
            fas_pkg::MODE_CALIB:
            begin
                r.calibrate = 1'b1;
                st.calibrated = 1'b1;
                st.mode = fas_pkg::MODE_WAIT_ARM;
            end
            fas_pkg::MODE_WAIT_ARM:
                if (st.pending == fas_pkg::EV_ARM)
                begin
                    st.pending = fas_pkg::EV_NONE;
                    st.mode = fas_pkg::MODE_ARMING;
                    st.arming_start = p.now_us;
                end
            fas_pkg::MODE_ARMING:
            begin
                r.esc_idle = 1'b1;
                if (period_passed(p.now_us, st.arming_start,
                                  cfg_regs[fas_pkg::REG_ARMING_TIME]))
                begin
                    st.mode = fas_pkg::MODE_RUNNING;
                    st.armed = 1'b1;
                end
            end
            fas_pkg::MODE_RUNNING:
                if (st.pending == fas_pkg::EV_DISARM)
                begin
                    st.pending = fas_pkg::EV_NONE;
                    st.mode = fas_pkg::MODE_WAIT_ARM;
                    st.armed = 1'b0;
                end
                else if (st.pending == fas_pkg::EV_TIMEOUT)
                begin
                    st.pending = fas_pkg::EV_NONE;
                    st.mode = fas_pkg::MODE_FAILSAFE;
                end
                else if (period_passed(p.now_us, st.last_control,
                                       cfg_regs[fas_pkg::REG_CONTROL_PERIOD]))
                begin
                    r.run_control = 1'b1;
                    st.last_control = p.now_us;
                end
            fas_pkg::MODE_FAILSAFE:
                r.esc_idle = 1'b1;
            default:
                ;
        endcase
        r.mode = st.mode;
        r.armed = st.armed;
        r.imu_ready = st.calibrated;
        r.set_roll = st.roll;
        r.set_pitch = st.pitch;
        r.set_yaw = st.yaw;
        r.set_throttle = st.throttle;
        return r;
    endfunction

    function automatic fas_pkg::pass_t make_pass(
        input logic [fas_pkg::TIME_W-1:0] now,
        input fas_pkg::cmd_t cmd,
        input logic arm,
        input logic [fas_pkg::SP_W-1:0] roll,
        input logic [fas_pkg::SP_W-1:0] pitch,
        input logic [fas_pkg::SP_W-1:0] yaw,
        input logic [fas_pkg::SP_W-1:0] throttle
    );
        fas_pkg::pass_t p;
        p.now_us = now;
        p.cmd = cmd;
        p.arm_request = arm;
        p.stick_roll = roll;
        p.stick_pitch = pitch;
        p.stick_yaw = yaw;
        p.stick_throttle = throttle;
        return p;
    endfunction

    // mostly small time steps, some aimed at or just before a timer boundary
    function automatic fas_pkg::pass_t random_pass();
        fas_pkg::pass_t p;
        logic [fas_pkg::TIME_W-1:0] mark;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            p.now_us = last_now;
        else if (pick < 20)
        begin
            case ($urandom_range(4))
                0: mark = steer_state.last_radio + cfg_regs[fas_pkg::REG_RADIO_TIMEOUT];
                1: mark = steer_state.last_imu + cfg_regs[fas_pkg::REG_IMU_PERIOD];
                2: mark = steer_state.last_mag + cfg_regs[fas_pkg::REG_MAG_PERIOD];
                3: mark = steer_state.last_control + cfg_regs[fas_pkg::REG_CONTROL_PERIOD];
                default: mark = steer_state.arming_start + cfg_regs[fas_pkg::REG_ARMING_TIME];
            endcase
            p.now_us = mark - fas_pkg::TIME_W'($urandom_range(1));
        end
        else if (pick < 24)
            p.now_us = $urandom;
        else
            p.now_us = last_now + fas_pkg::TIME_W'($urandom_range(step_max));
        pick = $urandom_range(99);
        if (pick < 40)
            p.cmd = fas_pkg::CMD_NONE;
        else if (pick < 65)
            p.cmd = fas_pkg::CMD_ARM_DISARM;
        else if (pick < 90)
            p.cmd = fas_pkg::CMD_STICKS;
        else
            p.cmd = fas_pkg::CMD_OTHER;
        p.arm_request = ($urandom_range(99) < 65);
        p.stick_roll = fas_pkg::SP_W'($urandom);
        p.stick_pitch = fas_pkg::SP_W'($urandom);
        p.stick_yaw = fas_pkg::SP_W'($urandom);
        p.stick_throttle = fas_pkg::SP_W'($urandom);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
            $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    task automatic check_result(input fas_pkg::result_t got, input fas_pkg::result_t want);
        compare_field("mode", 32'(want.mode), 32'(got.mode));
        compare_field("armed", 32'(want.armed), 32'(got.armed));
        compare_field("imu_ready", 32'(want.imu_ready), 32'(got.imu_ready));
        compare_field("mag_update", 32'(want.mag_update), 32'(got.mag_update));
        compare_field("imu_read", 32'(want.imu_read), 32'(got.imu_read));
        compare_field("calibrate", 32'(want.calibrate), 32'(got.calibrate));
        compare_field("esc_idle", 32'(want.esc_idle), 32'(got.esc_idle));
        compare_field("run_control", 32'(want.run_control), 32'(got.run_control));
        compare_field("set_roll", 32'(want.set_roll), 32'(got.set_roll));
        compare_field("set_pitch", 32'(want.set_pitch), 32'(got.set_pitch));
        compare_field("set_yaw", 32'(want.set_yaw), 32'(got.set_yaw));
        compare_field("set_throttle", 32'(want.set_throttle), 32'(got.set_throttle));
    endtask

    // failsafe is absorbing, so it is steered around until the closing phases
    task automatic queue_pass(input fas_pkg::pass_t p);
        flight_state_t trial;
        trial = steer_state;
        void'(supervise_pass(trial, p));
        if (trial.mode == fas_pkg::MODE_FAILSAFE && !failsafe_allowed)
        begin
            p.now_us = last_now;
            p.cmd = fas_pkg::CMD_ARM_DISARM;
            p.arm_request = 1'b0;
            trial = steer_state;
            void'(supervise_pass(trial, p));
        end
        steer_state = trial;
        last_now = p.now_us;
        pending_passes.push_back(p);
        queued_count++;
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
            queue_pass(random_pass());
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (accepted_count != queued_count || expected_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [fas_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fas_pkg::TIME_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_regs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(
        input logic [fas_pkg::TIME_W-1:0] power_on,
        input logic [fas_pkg::TIME_W-1:0] arming,
        input logic [fas_pkg::TIME_W-1:0] radio,
        input logic [fas_pkg::TIME_W-1:0] imu,
        input logic [fas_pkg::TIME_W-1:0] mag,
        input logic [fas_pkg::TIME_W-1:0] control
    );
        write_reg(fas_pkg::REG_POWER_ON_DELAY, power_on);
        write_reg(fas_pkg::REG_ARMING_TIME, arming);
        write_reg(fas_pkg::REG_RADIO_TIMEOUT, radio);
        write_reg(fas_pkg::REG_IMU_PERIOD, imu);
        write_reg(fas_pkg::REG_MAG_PERIOD, mag);
        write_reg(fas_pkg::REG_CONTROL_PERIOD, control);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!pass_ch.valid || pass_taken))
        begin
            if (pending_passes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pass_ch.valid <= 1'b1;
                pass_ch.data <= pending_passes.pop_front();
            end
            else
                pass_ch.valid <= 1'b0;
        end
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pass_ch.valid && pass_ch.ready)
            begin
                expected_results.push_back(supervise_pass(model_state, pass_ch.data));
                accepted_count++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                    check_result(result_ch.data, expected_results.pop_front());
                result_count++;
            end
        end
        pass_taken <= rst_n && pass_ch.valid && pass_ch.ready;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pass_ch.valid = 1'b0;
        pass_ch.data = '0;
        result_ch.ready = 1'b0;
        pass_taken = 1'b0;
        queued_count = 0;
        accepted_count = 0;
        result_count = 0;
        error_count = 0;
        send_idle_pct = 12;
        recv_idle_pct = 12;
        failsafe_allowed = 1'b0;
        last_now = '0;
        step_max = 1000;
        cfg_regs[fas_pkg::REG_POWER_ON_DELAY] = fas_pkg::POWER_ON_DELAY_RST;
        cfg_regs[fas_pkg::REG_ARMING_TIME] = fas_pkg::ARMING_TIME_RST;
        cfg_regs[fas_pkg::REG_RADIO_TIMEOUT] = fas_pkg::RADIO_TIMEOUT_RST;
        cfg_regs[fas_pkg::REG_IMU_PERIOD] = fas_pkg::IMU_PERIOD_RST;
        cfg_regs[fas_pkg::REG_MAG_PERIOD] = fas_pkg::MAG_PERIOD_RST;
        cfg_regs[fas_pkg::REG_CONTROL_PERIOD] = fas_pkg::CONTROL_PERIOD_RST;
        model_state = reset_flight_state();
        steer_state = reset_flight_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // power-on with reset settings, then a power-on delay that ends only at the wrap
        queue_pass(make_pass(32'd0, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        queue_pass(make_pass(32'd2999999, fas_pkg::CMD_OTHER, 1'b1, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF));
        settle();
        write_reg(fas_pkg::REG_POWER_ON_DELAY, T_MAX);
        queue_pass(make_pass(32'd3000000, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'hFFFF_FFFE, fas_pkg::CMD_STICKS, 1'b0, 16'h8000, 16'h7FFF,
                             16'hFFFF, 16'h0000));
        queue_pass(make_pass(T_MAX, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        // arm held pending across calibration
        queue_pass(make_pass(32'd0, fas_pkg::CMD_ARM_DISARM, 1'b1, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd10, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        queue_pass(make_pass(32'd20, fas_pkg::CMD_ARM_DISARM, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        settle();
        write_reg(fas_pkg::REG_ARMING_TIME, 32'd100);
        queue_pass(make_pass(32'd110, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        queue_pass(make_pass(32'd120, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        queue_pass(make_pass(32'd130, fas_pkg::CMD_ARM_DISARM, 1'b1, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd230, fas_pkg::CMD_STICKS, 1'b1, 16'h7FFF, 16'h8000,
                             16'h0000, 16'hFFFF));
        queue_pass(make_pass(32'd4000, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        queue_pass(make_pass(32'd7999, fas_pkg::CMD_OTHER, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd8000, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
        queue_pass(make_pass(32'd50000, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd50001, fas_pkg::CMD_ARM_DISARM, 1'b1, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd54001, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd54002, fas_pkg::CMD_ARM_DISARM, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        settle();
        // zero timeout overrides an arm in the same pass
        write_reg(fas_pkg::REG_RADIO_TIMEOUT, 32'd0);
        queue_pass(make_pass(32'd54003, fas_pkg::CMD_ARM_DISARM, 1'b1, 16'h0, 16'h0, 16'h0,
                             16'h0));
        settle();
        write_reg(fas_pkg::REG_RADIO_TIMEOUT, 32'd1000000);
        queue_pass(make_pass(32'd54004, fas_pkg::CMD_ARM_DISARM, 1'b1, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd54004, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd54104, fas_pkg::CMD_NONE, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        queue_pass(make_pass(32'd54105, fas_pkg::CMD_ARM_DISARM, 1'b0, 16'h0, 16'h0, 16'h0,
                             16'h0));
        settle();

        load_config(T_MAX, 32'd2000, 32'd20000, 32'd500, 32'd1500, 32'd700);
        step_max = 1500;
        queue_random(250);
        settle();
        queue_random(250);
        settle();

        load_config(32'd0, 32'd0, T_MAX, 32'd0, 32'd0, 32'd0);
        step_max = 50;
        queue_random(400);
        settle();

        load_config(T_MAX, T_MAX, 32'd3000, T_MAX, T_MAX, T_MAX);
        step_max = 1000;
        queue_random(350);
        settle();

        // back-to-back stretch with no idling on either side
        load_config(T_MAX, 32'd300, 32'd6000, 32'd400, 32'd2500, 32'd250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        step_max = 600;
        queue_random(400);
        settle();

        // radio silence while running, into failsafe for good
        send_idle_pct = 12;
        recv_idle_pct = 12;
        failsafe_allowed = 1'b1;
        for (int n = 0; n < 100 && steer_state.mode != fas_pkg::MODE_FAILSAFE; n++)
        begin
            if (steer_state.mode == fas_pkg::MODE_WAIT_ARM)
                queue_pass(make_pass(last_now + 32'd100, fas_pkg::CMD_ARM_DISARM, 1'b1,
                                     16'h0, 16'h0, 16'h0, 16'h0));
            else
                queue_pass(make_pass(last_now + 32'd1000, fas_pkg::CMD_NONE, 1'b0,
                                     16'h0, 16'h0, 16'h0, 16'h0));
        end
        queue_random(40);
        settle();

        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_random(30);
        settle();
        load_config(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX);
        queue_random(30);
        settle();

        repeat (10) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
